[rtl/msb_first_bit_reader_fifo_assert.svh]
// ----------------------------------------------------------------------------
// msb_first_bit_reader_fifo assertion macros
// concurrent checks on clk and rst_n, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_READER_FIFO_ASSERT_SVH
`define MSB_FIRST_BIT_READER_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define MBR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit reader check failed");
// consequent must hold in the cycle after the antecedent
`define MBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit reader check failed");
`else
`define MBR_ASSERT_SAME(lbl, ante, cons)
`define MBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/mbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_pkg
// shared codes, constants and the hex digit decoder of the bit reader
// ----------------------------------------------------------------------------
package mbr_pkg;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_RAW  = 2'd0,
        FUNC_HEX  = 2'd1,
        FUNC_TAKE = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_BAD_HEX = 3'd1,
        STAT_SHORT   = 3'd2,
        STAT_OVER    = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    // bit position value meaning the current byte is used up
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // ascii codes of the hex digit ranges
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_UA   = 8'h41;
    localparam logic [7:0] ASCII_UF   = 8'h46;
    localparam logic [7:0] ASCII_LA   = 8'h61;
    localparam logic [7:0] ASCII_LF   = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        hex_decode = 5'b0_0000;
        if (c inside {[ASCII_UA:ASCII_UF]})
        begin
            d = c - ASCII_UA + HEX_TEN;
            hex_decode = {1'b1, d[3:0]};
        end
        else if (c inside {[ASCII_LA:ASCII_LF]})
        begin
            d = c - ASCII_LA + HEX_TEN;
            hex_decode = {1'b1, d[3:0]};
        end
        else if (c inside {[ASCII_ZERO:ASCII_NINE]})
        begin
            d = c - ASCII_ZERO;
            hex_decode = {1'b1, d[3:0]};
        end
    endfunction

endpackage

[rtl/mbr_byte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_byte_ram
// single-port byte store, registered read data
// ----------------------------------------------------------------------------
module mbr_byte_ram #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [DEPTH];

    // one access per cycle, write or read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[rtl/mbr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_ctrl
// request sequencer: fifo pointers, hex pairing and the bit take loop
// ----------------------------------------------------------------------------
module mbr_ctrl #(
    parameter int FIFO_DEPTH = 256,
    parameter int MAX_TAKE   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [7:0]                          data,
    input  logic [5:0]                          amount,
    output logic                                mem_en,
    output logic                                mem_we,
    output logic [$clog2(FIFO_DEPTH)-1:0]       mem_addr,
    output logic [7:0]                          mem_wdata,
    input  logic [7:0]                          mem_rdata,
    output logic                                done,
    output logic [MAX_TAKE-1:0]                 acc,
    output mbr_pkg::status_t                    status,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     count,
    output logic [$clog2(FIFO_DEPTH+1)+3:0]     left
);

    import mbr_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = CW + 4;
    localparam int RW = $clog2(MAX_TAKE + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(FIFO_DEPTH - 1);
    localparam logic [6:0]    TAKE_LIMIT = 7'(MAX_TAKE);

    typedef enum logic {
        ST_IDLE,
        ST_TAKE
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [7:0]         cur_byte_reg, cur_byte_next;
    logic [3:0]         bit_pos_reg, bit_pos_next;
    logic [3:0]         held_reg, held_next;
    logic               waiting_reg, waiting_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic               pend_reg, pend_next;
    logic [MAX_TAKE-1:0] acc_reg, acc_next;
    status_t            status_reg, status_next;
    logic               done_reg, done_next;

    logic [4:0]         hex;
    logic               push_req;
    logic [7:0]         push_val;
    logic [3:0]         part;
    logic [6:0]         amt7;
    logic [7:0]         src;
    logic [3:0]         pos;
    logic [3:0]         avail;
    logic [3:0]         take_k;
    logic [7:0]         aligned;
    logic [7:0]         chunk;

    // unread bits, stored bytes plus the rest of the current byte
    assign part = (bit_pos_reg >= BYTE_BITS) ? 4'd0 : (BYTE_BITS - bit_pos_reg);
    assign left = LW'({count_reg, 3'b000}) + LW'(part);
    assign amt7 = {1'b0, amount};
    assign hex  = hex_decode(data);

    // byte source for the take loop: fresh memory data or the current byte
    assign src     = pend_reg ? mem_rdata : cur_byte_reg;
    assign pos     = pend_reg ? 4'd0 : bit_pos_reg;
    assign avail   = BYTE_BITS - pos;
    assign take_k  = (8'(rem_reg) < 8'(avail)) ? 4'(rem_reg) : avail;
    assign aligned = src << pos[2:0];
    assign chunk   = aligned >> (BYTE_BITS - take_k);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cur_byte_next = cur_byte_reg;
        bit_pos_next  = bit_pos_reg;
        held_next     = held_reg;
        waiting_next  = waiting_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        push_req      = 1'b0;
        push_val      = data;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = tail_reg;
        mem_wdata     = data;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_next = STAT_OK;
                    acc_next    = '0;
                    done_next   = 1'b1;
                    case (func)
                        FUNC_RAW:
                        begin
                            push_req = 1'b1;
                        end
                        FUNC_HEX:
                        begin
                            if (!hex[4])
                            begin
                                status_next = STAT_BAD_HEX;
                            end
                            else if (!waiting_reg)
                            begin
                                held_next    = hex[3:0];
                                waiting_next = 1'b1;
                            end
                            else
                            begin
                                waiting_next = 1'b0;
                                held_next    = 4'd0;
                                push_req     = 1'b1;
                                push_val     = {held_reg, hex[3:0]};
                            end
                        end
                        FUNC_TAKE:
                        begin
                            if (LW'(amount) > left)
                            begin
                                status_next = STAT_SHORT;
                            end
                            else if (amt7 > TAKE_LIMIT)
                            begin
                                status_next = STAT_OVER;
                            end
                            else if (amount != 6'd0)
                            begin
                                done_next  = 1'b0;
                                state_next = ST_TAKE;
                                rem_next   = RW'(amt7);
                                pend_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase

                    // byte push into the store
                    if (push_req)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_en     = 1'b1;
                            mem_we     = 1'b1;
                            mem_addr   = tail_reg;
                            mem_wdata  = push_val;
                            tail_next  = (tail_reg == LAST_ADDR) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_TAKE:
            begin
                if (!pend_reg && (bit_pos_reg == BYTE_BITS))
                begin
                    // current byte used up, fetch the next one
                    mem_en     = 1'b1;
                    mem_addr   = head_reg;
                    head_next  = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    // take what this byte can give
                    acc_next      = (acc_reg << take_k) | MAX_TAKE'(chunk);
                    cur_byte_next = src;
                    bit_pos_next  = pos + take_k;
                    rem_next      = rem_reg - RW'(take_k);
                    pend_next     = 1'b0;
                    if (rem_next != '0)
                    begin
                        mem_en     = 1'b1;
                        mem_addr   = head_reg;
                        head_next  = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            cur_byte_reg <= 8'd0;
            bit_pos_reg  <= BYTE_BITS;
            held_reg     <= 4'd0;
            waiting_reg  <= 1'b0;
            rem_reg      <= '0;
            pend_reg     <= 1'b0;
            acc_reg      <= '0;
            status_reg   <= STAT_OK;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cur_byte_reg <= cur_byte_next;
            bit_pos_reg  <= bit_pos_next;
            held_reg     <= held_next;
            waiting_reg  <= waiting_next;
            rem_reg      <= rem_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            status_reg   <= status_next;
            done_reg     <= done_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign acc    = acc_reg;
    assign status = status_reg;
    assign count  = count_reg;

endmodule

[rtl/msb_first_bit_reader_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_fifo
// byte fifo read out as an msb-first bit stream, with hex digit pairing
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. func
// selects a raw byte push (data), one ascii hex digit (data, two digits make
// a byte, high nibble first) or a take of amount bits (0 to MAX_TAKE).
// Each request gives one result: done is high for exactly one cycle with
// bits, status, bits_left and is_empty; the receiver cannot stall it.
// Pushes, hex digits, errors and zero-bit takes answer in the cycle after the
// request and busy stays low, so they run at one request per cycle.
// A take runs one byte per cycle through the single-port byte store: it
// holds busy while it works through each byte it touches, with an extra
// fetch step first when the current byte is already used up, and done
// follows the last of those steps. A new request is taken in the cycle
// that done is shown.
// Reset empties the fifo and drops any held hex nibble; the store itself is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "msb_first_bit_reader_fifo_assert.svh"

module msb_first_bit_reader_fifo #(
    parameter int FIFO_DEPTH = 256,
    parameter int MAX_TAKE   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [7:0]  data,
    input  logic [5:0]  amount,
    output logic        done,
    output logic [31:0] bits,
    output logic [2:0]  status,
    output logic [11:0] bits_left,
    output logic        is_empty
);

    import mbr_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = CW + 4;
    localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

    logic                mem_en;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    logic [MAX_TAKE-1:0] acc_w;
    status_t             status_w;
    logic [CW-1:0]       count_w;
    logic [LW-1:0]       left_w;
    logic [LW+11:0]      left_ext;
    logic [MAX_TAKE+31:0] acc_ext;

    // byte store
    mbr_byte_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // request sequencer
    mbr_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .MAX_TAKE   (MAX_TAKE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .data      (data),
        .amount    (amount),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .done      (done),
        .acc       (acc_w),
        .status    (status_w),
        .count     (count_w),
        .left      (left_w)
    );

    // result fields fitted to the port widths
    assign acc_ext   = {32'd0, acc_w};
    assign bits      = acc_ext[31:0];
    assign status    = status_w;
    assign left_ext  = {12'd0, left_w};
    assign bits_left = left_ext[11:0];
    assign is_empty  = (left_w == '0);

    // checks
    `MBR_ASSERT_SAME(a_done_when_idle, done, !busy)
    `MBR_ASSERT_NEXT(a_request_answered, start && !busy, done || busy)
    `MBR_ASSERT_SAME(a_count_bound, 1'b1, count_w <= FULL_COUNT)
    `MBR_ASSERT_SAME(a_error_no_bits, done && (status_w != STAT_OK), bits == 32'd0)

endmodule
